FILE: rtl/simq_pkg.sv
// simq_pkg: shared widths, codes and the per-cell control word for the sorted min queue.
// No dependencies; compiled first.
package simq_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int COUNT_OUT_W = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Broadcast to every cell in the chain each cycle
    typedef struct packed {
        logic                     load;
        logic                     insert;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

FILE: rtl/simq_if.sv
// simq_in_if / simq_out_if: valid/ready channels carrying the request and result beats.
// Depends on simq_pkg.
interface simq_in_if import simq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface simq_out_if import simq_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [DATA_W-1:0]      smallest;
    logic signed [DATA_W-1:0]      largest;
    logic        [COUNT_OUT_W-1:0] entry_count;
    logic        [1:0]             status;

    modport source (output valid, output smallest, output largest, output entry_count,
                    output status, input ready);
    modport sink   (input valid, input smallest, input largest, input entry_count,
                    input status, output ready);
endinterface

FILE: rtl/simq_cell.sv
// simq_cell: one slot of the sorted chain. Compares its entry with the broadcast value
// and shifts in from the left (insert) or right (pop). Depends on simq_pkg.
module simq_cell import simq_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_occ,
    input  logic                     i_left_lt,
    input  logic signed [DATA_W-1:0] i_left_val,
    input  logic signed [DATA_W-1:0] i_right_val,
    output logic signed [DATA_W-1:0] o_val,
    output logic signed [DATA_W-1:0] o_next,
    output logic                     o_lt
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    // Held entry strictly below the new value: it stays where it is
    assign o_lt  = i_occ && ($signed(r_val) < $signed(i_ctl.value));
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.load) begin
            if (i_ctl.insert) begin
                if (o_lt) begin
                    n_val = r_val;
                end else if (i_left_lt) begin
                    n_val = i_ctl.value;
                end else begin
                    n_val = i_left_val;
                end
            end else begin
                n_val = i_right_val;
            end
        end
    end

    assign o_next = n_val;

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: rtl/sorted_insert_min_queue_unit.sv
// Sorted min queue: a result beat is valid in the cycle after its request is accepted.
// Throughput is one beat per cycle while the result is taken; every cell compares against
// the new value at once and the chain shifts one place in that same cycle.
// Reset (synchronous, active low) empties the queue and drops any pending result; the
// entry storage itself is not cleared and needs no clearing pass.
// Depends on simq_pkg, simq_if and simq_cell.
module sorted_insert_min_queue_unit import simq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    simq_in_if.sink     i_in,
    simq_out_if.source  o_out
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_largest;
    logic signed [DATA_W-1:0] n_largest;
    logic signed [DATA_W-1:0] r_smallest_out;
    logic signed [DATA_W-1:0] r_largest_out;
    logic [COUNT_OUT_W-1:0]   r_count_out;
    t_status                  r_status;
    t_status                  n_status;

    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    logic                     ins_ok;
    logic                     pop_ok;
    logic                     at_end;
    t_cell_ctl                ctl;

    logic signed [DATA_W-1:0] w_val  [CAPACITY];
    logic signed [DATA_W-1:0] w_next [CAPACITY];
    logic [CAPACITY-1:0]      w_lt;
    logic [CAPACITY-1:0]      w_occ;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign ins_ok   = accept && (i_in.operation == OP_INSERT) && !is_full;
    assign pop_ok   = accept && (i_in.operation == OP_POP) && !is_empty;

    assign ctl.load   = ins_ok || pop_ok;
    assign ctl.insert = (i_in.operation == OP_INSERT);
    assign ctl.value  = i_in.value;

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic                     left_lt;
            logic signed [DATA_W-1:0] left_val;
            logic signed [DATA_W-1:0] right_val;

            assign w_occ[i] = (CNT_W'(i) < r_count);

            if (i == 0) begin : g_head
                assign left_lt  = 1'b1;
                assign left_val = i_in.value;
            end else begin : g_body
                assign left_lt  = w_lt[i-1];
                assign left_val = w_val[i-1];
            end

            if (i == CAPACITY - 1) begin : g_tail
                assign right_val = i_in.value;
            end else begin : g_inner
                assign right_val = w_val[i+1];
            end

            simq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occ       (w_occ[i]),
                .i_left_lt   (left_lt),
                .i_left_val  (left_val),
                .i_right_val (right_val),
                .o_val       (w_val[i]),
                .o_next      (w_next[i]),
                .o_lt        (w_lt[i])
            );
        end
    endgenerate

    // New value lands past every held entry, so it becomes the largest
    assign at_end = &(w_lt | ~w_occ);

    always_comb begin
        n_count   = r_count;
        n_largest = r_largest;
        n_status  = ST_DONE;
        if (accept) begin
            if (i_in.operation == OP_INSERT) begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    if (at_end) begin
                        n_largest = i_in.value;
                    end
                end
            end else begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result beat payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_largest      <= n_largest;
            r_smallest_out <= (n_count == '0) ? '0 : w_next[0];
            r_largest_out  <= (n_count == '0) ? '0 : n_largest;
            r_count_out    <= COUNT_OUT_W'(n_count);
            r_status       <= n_status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.smallest    = r_smallest_out;
    assign o_out.largest     = r_largest_out;
    assign o_out.entry_count = r_count_out;
    assign o_out.status      = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted beat gave no result");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_full && (i_in.operation == OP_INSERT)) |=> (r_count == $past(r_count)))
        else $error("dropped insert changed the count");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($signed(o_out.smallest) <= $signed(o_out.largest)))
        else $error("smallest above largest");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("not ready with empty result register");

endmodule

FILE: test/tb_sorted_insert_min_queue_unit.sv
// Testbench for sorted_insert_min_queue_unit: directed table then bursty random inserts/pops,
// results checked against typed rows or a queue predictor. Depends on simq_pkg and simq_if.
`timescale 1ns / 100ps

module tb_sorted_insert_min_queue_unit;
    import simq_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 338;
    localparam int SETTLE_CYCLES   = 8;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0]  smallest;
        logic signed [DATA_W-1:0]  largest;
        logic [COUNT_OUT_W-1:0]    entry_count;
        t_status                   status;
    } t_queue_report;

    typedef struct {
        bit            typed;
        t_queue_report report;
    } t_report_source;

    typedef struct {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        t_queue_report            report;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    simq_in_if  req_if ();
    simq_out_if res_if ();

    sorted_insert_min_queue_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    logic signed [DATA_W-1:0] shadow_q[$];
    t_queue_report            expected_reports[$];
    t_report_source           report_sources[$];
    int                       error_count;
    int                       cycle_count;
    int                       send_idle_pct;
    int                       take_stall_pct;
    t_directed_row            directed_rows[22];

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // Shadow of the sorted store; an insert goes before the first entry not below it
    function automatic t_queue_report predict_queue_step(t_op op,
                                                         logic signed [DATA_W-1:0] value);
        t_queue_report rpt;
        int            pos;
        rpt.status = ST_DONE;
        if (op == OP_INSERT) begin
            if (shadow_q.size() >= CAPACITY) begin
                rpt.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_q.size() && shadow_q[pos] < value)
                    pos++;
                shadow_q.insert(pos, value);
            end
        end else begin
            if (shadow_q.size() == 0)
                rpt.status = ST_EMPTY;
            else
                shadow_q.delete(0);
        end
        if (shadow_q.size() == 0) begin
            rpt.smallest = '0;
            rpt.largest  = '0;
        end else begin
            rpt.smallest = shadow_q[0];
            rpt.largest  = shadow_q[shadow_q.size() - 1];
        end
        rpt.entry_count = COUNT_OUT_W'(shadow_q.size());
        return rpt;
    endfunction

    task automatic check_report(t_queue_report got);
        t_queue_report want;
        if (expected_reports.size() == 0) begin
            $display("%0t: result beat with nothing expected (smallest %0d largest %0d %s",
                     $time, got.smallest, got.largest, "");
            $display("%0t:   count %0d status %0d)", $time, got.entry_count, got.status);
            error_count++;
        end else begin
            want = expected_reports[0];
            expected_reports.delete(0);
            if (got.smallest !== want.smallest) begin
                $display("%0t: smallest expected %0d got %0d", $time, want.smallest, got.smallest);
                error_count++;
            end
            if (got.largest !== want.largest) begin
                $display("%0t: largest expected %0d got %0d", $time, want.largest, got.largest);
                error_count++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count expected %0d got %0d", $time,
                         want.entry_count, got.entry_count);
                error_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                error_count++;
            end
        end
    endtask

    // Request beats are predicted before result beats of the same edge
    always @(posedge i_clk) begin : monitor
        t_report_source src;
        t_queue_report  predicted;
        t_queue_report  got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                src = report_sources[0];
                report_sources.delete(0);
                predicted = predict_queue_step(t_op'(req_if.operation), req_if.value);
                expected_reports.insert(expected_reports.size(),
                                        src.typed ? src.report : predicted);
            end
            if (res_if.valid === 1'b1 && res_if.ready) begin
                got.smallest    = res_if.smallest;
                got.largest     = res_if.largest;
                got.entry_count = res_if.entry_count;
                got.status      = t_status'(res_if.status);
                check_report(got);
            end
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= take_stall_pct);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_sorted_insert_min_queue_unit: done, errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(t_op op, logic signed [DATA_W-1:0] value, bit typed,
                             t_queue_report report);
        t_report_source src;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        src.typed  = typed;
        src.report = report;
        report_sources.insert(report_sources.size(), src);
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= value;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_reports.size() != 0 || report_sources.size() != 0)
            @(negedge i_clk);
    endtask

    // Random values, small values around zero, extremes, and some near held entries so that equal keys turn up
    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned sel;
        int          idx;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            return $urandom;
        if (sel <= 6)
            return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
        if (sel == 7) begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        if (shadow_q.size() == 0)
            return $urandom;
        idx = $urandom_range(0, shadow_q.size() - 1);
        return shadow_q[idx] + DATA_W'($urandom_range(0, 2)) - DATA_W'(1);
    endfunction

    initial begin : stimulus
        int  phase;
        int  remaining;
        int  burst;
        int  pop_pct;
        t_op op;

        error_count      = 0;
        send_idle_pct    = 0;
        take_stall_pct   = 0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_INSERT;
        req_if.value     = '0;
        res_if.ready     = 1'b0;

        // Pop on empty, fill to capacity with extremes and duplicates, overflow; then pop, refill, overflow, pop
        directed_rows = '{
            '{OP_POP,    '0,                1'b1, '{'0, '0, 5'd0, ST_EMPTY}},
            '{OP_INSERT, VAL_MAX,           1'b1, '{VAL_MAX, VAL_MAX, 5'd1, ST_DONE}},
            '{OP_INSERT, VAL_MIN,           1'b1, '{VAL_MIN, VAL_MAX, 5'd2, ST_DONE}},
            '{OP_INSERT, 32'sd0,            1'b0, '0},
            '{OP_INSERT, -32'sd1,           1'b0, '0},
            '{OP_INSERT, 32'sd1,            1'b0, '0},
            '{OP_INSERT, 32'sd0,            1'b0, '0},
            '{OP_INSERT, 32'sh5555_5555,    1'b0, '0},
            '{OP_INSERT, 32'shAAAA_AAAA,    1'b0, '0},
            '{OP_INSERT, -32'sd1,           1'b0, '0},
            '{OP_INSERT, 32'sd100,          1'b0, '0},
            '{OP_INSERT, -32'sd100,         1'b0, '0},
            '{OP_INSERT, 32'sh7FFF_FFFE,    1'b0, '0},
            '{OP_INSERT, 32'sh8000_0001,    1'b0, '0},
            '{OP_INSERT, 32'sd42,           1'b0, '0},
            '{OP_INSERT, 32'sd42,           1'b0, '0},
            '{OP_INSERT, 32'sd7,            1'b0, '0},
            '{OP_INSERT, 32'sd3,            1'b1, '{VAL_MIN, VAL_MAX, 5'd16, ST_FULL}},
            '{OP_POP,    32'sh1234_5678,    1'b0, '0},
            '{OP_INSERT, VAL_MIN,           1'b0, '0},
            '{OP_INSERT, 32'sd5,            1'b0, '0},
            '{OP_POP,    '1,                1'b0, '0}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_beat(directed_rows[r].op, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].report);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
                1: begin send_idle_pct = 48; take_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  take_stall_pct = 48; end
                default: begin send_idle_pct = 20; take_stall_pct = 20; end
            endcase
            hold_until_drained();
            remaining = ITEMS_PER_PHASE;
            while (remaining > 0) begin
                // bursts lean towards filling, draining or an even mix
                case ($urandom_range(0, 2))
                    0: pop_pct = 20;
                    1: pop_pct = 80;
                    default: pop_pct = 50;
                endcase
                burst = $urandom_range(8, 40);
                while (burst > 0 && remaining > 0) begin
                    op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT;
                    send_beat(op, pick_value(), 1'b0, '0);
                    burst--;
                    remaining--;
                end
            end
        end

        req_if.valid <= 1'b0;
        while (expected_reports.size() != 0 || report_sources.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_sorted_insert_min_queue_unit: done, clean");
        else
            $display("tb_sorted_insert_min_queue_unit: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/simq_pkg.sv
rtl/simq_if.sv
rtl/simq_cell.sv
rtl/sorted_insert_min_queue_unit.sv
test/tb_sorted_insert_min_queue_unit.sv
